@@ src/lobm_pkg.sv @@
package lobm_pkg;

    // Request codes.
    localparam logic OP_PLACE  = 1'b0;
    localparam logic OP_CANCEL = 1'b1;
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // Most results that one request may produce.
    localparam int MAX_RESULTS = 64;

    typedef enum logic [2:0] {
        EV_PLACED    = 3'd0,
        EV_BAD       = 3'd1,
        EV_DUP       = 3'd2,
        EV_FULL      = 3'd3,
        EV_TRADE     = 3'd4,
        EV_CANCELLED = 3'd5,
        EV_NOT_FOUND = 3'd6
    } t_event;

    typedef struct packed {
        logic        operation;
        logic [9:0]  req_id;
        logic        side;
        logic [15:0] quantity;
        logic [7:0]  price_tick;
    } t_lob_in;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [9:0]  subject_id;
        logic [9:0]  buy_id;
        logic [9:0]  sell_id;
        logic [15:0] trade_qty;
        logic [7:0]  buy_level;
        logic [7:0]  sell_level;
        logic        buy_done;
        logic        sell_done;
        logic        last;
    } t_lob_out;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_ALLOC,
        S_ENQ,
        S_LINK,
        S_MATCH,
        S_RD_BID,
        S_RD_ASK,
        S_SL_BUY,
        S_SL_SELL,
        S_WR_BUY,
        S_UN_START,
        S_UN_SLOT,
        S_UN_LVL,
        S_UN_MID,
        S_SCAN,
        S_UN_RET,
        S_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        U_CANCEL,
        U_BUY,
        U_SELL
    } t_umode;

endpackage

@@ src/limit_order_book_matcher.sv @@
// Channel   | Direction | Handshake                | Item
// ----------+-----------+--------------------------+-------------------------------
// request   | in        | i_in_valid / o_in_ready  | i_in_data  (lobm_pkg::t_lob_in)
// result    | out       | o_out_valid / i_out_ready| o_out_data (lobm_pkg::t_lob_out)
//
// One request at a time; o_in_ready is high only in the idle state. A reject or unknown
// cancel ends after the id lookup; a cancel unlinks its order, with an extra step for an
// order in mid queue. A place enqueues its order, then trades while the book crosses and
// unlinks each order that leaves the book; an emptied best level adds a walk, one level per cycle.
// After reset a clearing pass over max(ID_SPACE, 2 * 2**clog2(PRICE_LEVELS), ORDER_SLOTS)
// entries sweeps the id and level memories and fills the free-slot stack; no request is taken.
// Each result is held one step back so that the final one can carry last; a busy output
// register stalls the trade step and the final flush, which delays the next request.
module limit_order_book_matcher #(
    parameter int ORDER_SLOTS  = 64,
    parameter int PRICE_LEVELS = 256,
    parameter int ID_SPACE     = 1024,
    parameter int QTY_BITS     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lobm_pkg::t_lob_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lobm_pkg::t_lob_out o_out_data
);

    localparam int SB    = $clog2(ORDER_SLOTS);
    localparam int PB    = $clog2(PRICE_LEVELS);
    localparam int IAW   = $clog2(ID_SPACE);
    localparam int LAW   = PB + 1;
    localparam int LVL_N = 2 ** LAW;
    localparam int QB    = QTY_BITS;
    localparam int CLR_A = (ID_SPACE > LVL_N) ? ID_SPACE : LVL_N;
    localparam int CLR_N = (CLR_A > ORDER_SLOTS) ? CLR_A : ORDER_SLOTS;
    localparam int CW    = $clog2(CLR_N) + 1;
    localparam int NW    = $clog2(lobm_pkg::MAX_RESULTS) + 1;

    typedef struct packed {
        logic [9:0]    id;
        logic          side;
        logic [QB-1:0] qty;
        logic [PB-1:0] price;
        logic [SB-1:0] prev;
        logic [SB-1:0] next;
    } t_slot;

    typedef struct packed {
        logic          valid;
        logic [SB-1:0] head;
        logic [SB-1:0] tail;
    } t_level;

    typedef struct packed {
        logic          valid;
        logic [SB-1:0] slot;
    } t_idpos;

    // Memories.
    t_slot         slot_mem [ORDER_SLOTS];
    t_level        lvl_mem  [LVL_N];
    t_idpos        id_mem   [ID_SPACE];
    logic [SB-1:0] free_mem [ORDER_SLOTS];

    // Memory ports.
    logic          slot_re, slot_we_rec, slot_we_qty, slot_we_prev, slot_we_next;
    logic [SB-1:0] slot_ra, slot_wa;
    t_slot         slot_wd, r_slot_rd;
    logic          lvl_re, lvl_we;
    logic [LAW-1:0] lvl_ra, lvl_wa;
    t_level        lvl_wd, r_lvl_rd;
    logic          id_re, id_we;
    logic [IAW-1:0] id_ra, id_wa;
    t_idpos        id_wd, r_id_rd;
    logic          free_re, free_we;
    logic [SB-1:0] free_ra, free_wa, free_wd, r_free_rd;

    // Control and working registers.
    lobm_pkg::t_state   r_state, n_state;
    lobm_pkg::t_umode   r_umode, n_umode;
    logic               r_op, n_op, r_side, n_side;
    logic [9:0]         r_id, n_id;
    logic [QB-1:0]      r_qty, n_qty, r_bq, n_bq;
    logic [7:0]         r_price, n_price;
    logic [CW-1:0]      r_clr, n_clr;
    logic [SB:0]        r_free_cnt, n_free_cnt;
    logic               r_has_bid, n_has_bid, r_has_ask, n_has_ask;
    logic [PB-1:0]      r_bid, n_bid, r_ask, n_ask, r_scan, n_scan;
    logic [SB-1:0]      r_slot, n_slot, r_t, n_t, r_b, n_b, r_a, n_a, r_us, n_us;
    logic               r_link, n_link, r_bd, n_bd, r_ad, n_ad;
    t_slot              r_brec, n_brec, r_urec, n_urec;
    logic [NW-1:0]      r_nres, n_nres;
    lobm_pkg::t_lob_out r_pend, n_pend, r_out, n_out;
    logic               r_pend_v, n_pend_v, r_out_valid, n_out_valid;

    // Shared conditions.
    logic               w_out_free, w_stall, w_cross, w_oob, w_bad;
    logic [QB-1:0]      w_tq;
    logic               w_emit;
    lobm_pkg::t_lob_out w_emit_d;

    function automatic lobm_pkg::t_lob_out f_simple(lobm_pkg::t_event k, logic [9:0] id);
        lobm_pkg::t_lob_out o;
        o            = '0;
        o.event_kind = k;
        o.subject_id = id;
        return o;
    endfunction

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_stall    = (r_state == lobm_pkg::S_SL_SELL) && r_pend_v && !w_out_free;
    assign w_cross    = r_has_bid && r_has_ask && (r_ask <= r_bid);
    assign w_oob      = 32'(r_id) >= ID_SPACE;
    assign w_bad      = (r_qty == '0) || (r_price == 8'd0) ||
                        (32'(r_price) >= PRICE_LEVELS) || w_oob;
    assign w_tq       = (r_brec.qty < r_slot_rd.qty) ? r_brec.qty : r_slot_rd.qty;

    assign o_in_ready  = (r_state == lobm_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Memory arrays: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (slot_we_rec) begin
            slot_mem[slot_wa].id    <= slot_wd.id;
            slot_mem[slot_wa].side  <= slot_wd.side;
            slot_mem[slot_wa].price <= slot_wd.price;
        end
        if (slot_we_rec || slot_we_qty) begin
            slot_mem[slot_wa].qty <= slot_wd.qty;
        end
        if (slot_we_prev) begin
            slot_mem[slot_wa].prev <= slot_wd.prev;
        end
        if (slot_we_next) begin
            slot_mem[slot_wa].next <= slot_wd.next;
        end
        if (slot_re) begin
            r_slot_rd <= slot_mem[slot_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            lvl_mem[lvl_wa] <= lvl_wd;
        end
        if (lvl_re) begin
            r_lvl_rd <= lvl_mem[lvl_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (id_we) begin
            id_mem[id_wa] <= id_wd;
        end
        if (id_re) begin
            r_id_rd <= id_mem[id_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (free_we) begin
            free_mem[free_wa] <= free_wd;
        end
        if (free_re) begin
            r_free_rd <= free_mem[free_ra];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lobm_pkg::S_CLEAR: begin
                if (32'(r_clr) == CLR_N - 1) n_state = lobm_pkg::S_IDLE;
            end
            lobm_pkg::S_IDLE: begin
                if (i_in_valid) n_state = lobm_pkg::S_CHECK;
            end
            lobm_pkg::S_CHECK: begin
                if (r_op == lobm_pkg::OP_CANCEL) begin
                    if (w_oob || !r_id_rd.valid) n_state = lobm_pkg::S_FLUSH;
                    else                         n_state = lobm_pkg::S_UN_START;
                end else if (w_bad || r_id_rd.valid || r_free_cnt == '0) begin
                    n_state = lobm_pkg::S_FLUSH;
                end else begin
                    n_state = lobm_pkg::S_ALLOC;
                end
            end
            lobm_pkg::S_ALLOC:    n_state = lobm_pkg::S_ENQ;
            lobm_pkg::S_ENQ:      n_state = lobm_pkg::S_LINK;
            lobm_pkg::S_LINK:     n_state = lobm_pkg::S_MATCH;
            lobm_pkg::S_MATCH: begin
                if (w_cross && 32'(r_nres) < lobm_pkg::MAX_RESULTS) n_state = lobm_pkg::S_RD_BID;
                else                                                n_state = lobm_pkg::S_FLUSH;
            end
            lobm_pkg::S_RD_BID:   n_state = lobm_pkg::S_RD_ASK;
            lobm_pkg::S_RD_ASK:   n_state = lobm_pkg::S_SL_BUY;
            lobm_pkg::S_SL_BUY:   n_state = lobm_pkg::S_SL_SELL;
            lobm_pkg::S_SL_SELL: begin
                if (!w_stall) n_state = lobm_pkg::S_WR_BUY;
            end
            lobm_pkg::S_WR_BUY: begin
                if (r_bd || r_ad) n_state = lobm_pkg::S_UN_START;
                else              n_state = lobm_pkg::S_MATCH;
            end
            lobm_pkg::S_UN_START: n_state = lobm_pkg::S_UN_SLOT;
            lobm_pkg::S_UN_SLOT:  n_state = lobm_pkg::S_UN_LVL;
            lobm_pkg::S_UN_LVL: begin
                if (r_lvl_rd.head == r_us && r_lvl_rd.tail == r_us) begin
                    if (r_urec.side == lobm_pkg::SIDE_BUY && r_urec.price == r_bid &&
                        r_bid != '0) begin
                        n_state = lobm_pkg::S_SCAN;
                    end else if (r_urec.side == lobm_pkg::SIDE_SELL && r_urec.price == r_ask &&
                                 32'(r_ask) != PRICE_LEVELS - 1) begin
                        n_state = lobm_pkg::S_SCAN;
                    end else begin
                        n_state = lobm_pkg::S_UN_RET;
                    end
                end else if (r_lvl_rd.head != r_us && r_lvl_rd.tail != r_us) begin
                    n_state = lobm_pkg::S_UN_MID;
                end else begin
                    n_state = lobm_pkg::S_UN_RET;
                end
            end
            lobm_pkg::S_UN_MID:   n_state = lobm_pkg::S_UN_RET;
            lobm_pkg::S_SCAN: begin
                if (r_lvl_rd.valid) begin
                    n_state = lobm_pkg::S_UN_RET;
                end else if (r_urec.side == lobm_pkg::SIDE_BUY && r_scan == '0) begin
                    n_state = lobm_pkg::S_UN_RET;
                end else if (r_urec.side == lobm_pkg::SIDE_SELL &&
                             32'(r_scan) == PRICE_LEVELS - 1) begin
                    n_state = lobm_pkg::S_UN_RET;
                end
            end
            lobm_pkg::S_UN_RET: begin
                unique case (r_umode)
                    lobm_pkg::U_CANCEL: n_state = lobm_pkg::S_FLUSH;
                    lobm_pkg::U_BUY:    n_state = r_ad ? lobm_pkg::S_UN_START : lobm_pkg::S_MATCH;
                    default:            n_state = lobm_pkg::S_MATCH;
                endcase
            end
            lobm_pkg::S_FLUSH: begin
                if (w_out_free) n_state = lobm_pkg::S_IDLE;
            end
            default: n_state = lobm_pkg::S_CLEAR;
        endcase
    end

    // Datapath, memory controls and result emission.
    always_comb begin
        n_op = r_op;  n_id = r_id;  n_side = r_side;  n_qty = r_qty;  n_price = r_price;
        n_clr = r_clr;  n_free_cnt = r_free_cnt;
        n_has_bid = r_has_bid;  n_bid = r_bid;  n_has_ask = r_has_ask;  n_ask = r_ask;
        n_slot = r_slot;  n_link = r_link;  n_t = r_t;  n_b = r_b;  n_a = r_a;
        n_brec = r_brec;  n_bq = r_bq;  n_bd = r_bd;  n_ad = r_ad;
        n_us = r_us;  n_umode = r_umode;  n_urec = r_urec;  n_scan = r_scan;
        n_nres = r_nres;  n_pend = r_pend;  n_pend_v = r_pend_v;
        n_out = r_out;  n_out_valid = r_out_valid && !i_out_ready;

        slot_re = 1'b0;  slot_ra = '0;  slot_wa = '0;  slot_wd = '0;
        slot_we_rec = 1'b0;  slot_we_qty = 1'b0;  slot_we_prev = 1'b0;  slot_we_next = 1'b0;
        lvl_re = 1'b0;  lvl_ra = '0;  lvl_we = 1'b0;  lvl_wa = '0;  lvl_wd = '0;
        id_re = 1'b0;  id_ra = '0;  id_we = 1'b0;  id_wa = '0;  id_wd = '0;
        free_re = 1'b0;  free_ra = '0;  free_we = 1'b0;  free_wa = '0;  free_wd = '0;
        w_emit = 1'b0;  w_emit_d = '0;

        unique case (r_state)
            // Sweep the memories once after reset.
            lobm_pkg::S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (32'(r_clr) < ID_SPACE) begin
                    id_we = 1'b1;
                    id_wa = r_clr[IAW-1:0];
                end
                if (32'(r_clr) < LVL_N) begin
                    lvl_we = 1'b1;
                    lvl_wa = r_clr[LAW-1:0];
                end
                if (32'(r_clr) < ORDER_SLOTS) begin
                    free_we = 1'b1;
                    free_wa = r_clr[SB-1:0];
                    free_wd = r_clr[SB-1:0];
                end
            end
            // Take a request and look up its id.
            lobm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in_data.operation;
                    n_id    = i_in_data.req_id;
                    n_side  = i_in_data.side;
                    n_qty   = QB'(i_in_data.quantity);
                    n_price = i_in_data.price_tick;
                    n_nres  = '0;
                    id_re   = 1'b1;
                    id_ra   = IAW'(i_in_data.req_id);
                end
            end
            // Reject, dispatch a cancel, or fetch a free slot.
            lobm_pkg::S_CHECK: begin
                if (r_op == lobm_pkg::OP_CANCEL) begin
                    if (w_oob || !r_id_rd.valid) begin
                        w_emit   = 1'b1;
                        w_emit_d = f_simple(lobm_pkg::EV_NOT_FOUND, r_id);
                    end else begin
                        n_us    = r_id_rd.slot;
                        n_umode = lobm_pkg::U_CANCEL;
                    end
                end else if (w_bad) begin
                    w_emit   = 1'b1;
                    w_emit_d = f_simple(lobm_pkg::EV_BAD, r_id);
                end else if (r_id_rd.valid) begin
                    w_emit   = 1'b1;
                    w_emit_d = f_simple(lobm_pkg::EV_DUP, r_id);
                end else if (r_free_cnt == '0) begin
                    w_emit   = 1'b1;
                    w_emit_d = f_simple(lobm_pkg::EV_FULL, r_id);
                end else begin
                    free_re = 1'b1;
                    free_ra = SB'(r_free_cnt - 1'b1);
                end
            end
            // Fill the slot, mark the id, and read the level.
            lobm_pkg::S_ALLOC: begin
                n_slot        = r_free_rd;
                n_free_cnt    = r_free_cnt - 1'b1;
                slot_we_rec   = 1'b1;
                slot_wa       = r_free_rd;
                slot_wd.id    = r_id;
                slot_wd.side  = r_side;
                slot_wd.qty   = r_qty;
                slot_wd.price = PB'(r_price);
                id_we         = 1'b1;
                id_wa         = IAW'(r_id);
                id_wd         = '{valid: 1'b1, slot: r_free_rd};
                lvl_re        = 1'b1;
                lvl_ra        = {r_side, PB'(r_price)};
            end
            // Append at the tail and update the best price.
            lobm_pkg::S_ENQ: begin
                lvl_we = 1'b1;
                lvl_wa = {r_side, PB'(r_price)};
                if (!r_lvl_rd.valid) begin
                    lvl_wd = '{valid: 1'b1, head: r_slot, tail: r_slot};
                    n_link = 1'b0;
                end else begin
                    lvl_wd       = '{valid: 1'b1, head: r_lvl_rd.head, tail: r_slot};
                    slot_we_next = 1'b1;
                    slot_wa      = r_lvl_rd.tail;
                    slot_wd.next = r_slot;
                    n_link       = 1'b1;
                    n_t          = r_lvl_rd.tail;
                end
                if (r_side == lobm_pkg::SIDE_BUY) begin
                    if (!r_has_bid || PB'(r_price) > r_bid) begin
                        n_has_bid = 1'b1;
                        n_bid     = PB'(r_price);
                    end
                end else if (!r_has_ask || PB'(r_price) < r_ask) begin
                    n_has_ask = 1'b1;
                    n_ask     = PB'(r_price);
                end
            end
            // Back link of the new slot, then the placed item.
            lobm_pkg::S_LINK: begin
                if (r_link) begin
                    slot_we_prev = 1'b1;
                    slot_wa      = r_slot;
                    slot_wd.prev = r_t;
                end
                w_emit   = 1'b1;
                w_emit_d = f_simple(lobm_pkg::EV_PLACED, r_id);
            end
            lobm_pkg::S_MATCH: begin
                lvl_re = 1'b1;
                lvl_ra = {lobm_pkg::SIDE_BUY, r_bid};
            end
            lobm_pkg::S_RD_BID: begin
                n_b    = r_lvl_rd.head;
                lvl_re = 1'b1;
                lvl_ra = {lobm_pkg::SIDE_SELL, r_ask};
            end
            lobm_pkg::S_RD_ASK: begin
                n_a     = r_lvl_rd.head;
                slot_re = 1'b1;
                slot_ra = r_b;
            end
            lobm_pkg::S_SL_BUY: begin
                n_brec  = r_slot_rd;
                slot_re = 1'b1;
                slot_ra = r_a;
            end
            // Trade the smaller quantity of the two front orders.
            lobm_pkg::S_SL_SELL: begin
                if (!w_stall) begin
                    n_bq        = r_brec.qty - w_tq;
                    n_bd        = r_brec.qty <= r_slot_rd.qty;
                    n_ad        = r_slot_rd.qty <= r_brec.qty;
                    slot_we_qty = 1'b1;
                    slot_wa     = r_a;
                    slot_wd.qty = r_slot_rd.qty - w_tq;
                    w_emit              = 1'b1;
                    w_emit_d            = '0;
                    w_emit_d.event_kind = lobm_pkg::EV_TRADE;
                    w_emit_d.subject_id = r_id;
                    w_emit_d.buy_id     = r_brec.id;
                    w_emit_d.sell_id    = r_slot_rd.id;
                    w_emit_d.trade_qty  = 16'(w_tq);
                    w_emit_d.buy_level  = 8'(r_brec.price);
                    w_emit_d.sell_level = 8'(r_slot_rd.price);
                    w_emit_d.buy_done   = r_brec.qty <= r_slot_rd.qty;
                    w_emit_d.sell_done  = r_slot_rd.qty <= r_brec.qty;
                end
            end
            lobm_pkg::S_WR_BUY: begin
                slot_we_qty = 1'b1;
                slot_wa     = r_b;
                slot_wd.qty = r_bq;
                if (r_bd) begin
                    n_us    = r_b;
                    n_umode = lobm_pkg::U_BUY;
                end else if (r_ad) begin
                    n_us    = r_a;
                    n_umode = lobm_pkg::U_SELL;
                end
            end
            // Unlink a slot from its level queue.
            lobm_pkg::S_UN_START: begin
                slot_re = 1'b1;
                slot_ra = r_us;
            end
            lobm_pkg::S_UN_SLOT: begin
                n_urec = r_slot_rd;
                lvl_re = 1'b1;
                lvl_ra = {r_slot_rd.side, r_slot_rd.price};
            end
            lobm_pkg::S_UN_LVL: begin
                id_we      = 1'b1;
                id_wa      = IAW'(r_urec.id);
                free_we    = 1'b1;
                free_wa    = r_free_cnt[SB-1:0];
                free_wd    = r_us;
                n_free_cnt = r_free_cnt + 1'b1;
                lvl_wa     = {r_urec.side, r_urec.price};
                if (r_lvl_rd.head == r_us && r_lvl_rd.tail == r_us) begin
                    lvl_we = 1'b1;
                    lvl_wd = '0;
                    // The best level emptied: walk outward for the next one.
                    if (r_urec.side == lobm_pkg::SIDE_BUY && r_urec.price == r_bid) begin
                        if (r_bid == '0) begin
                            n_has_bid = 1'b0;
                        end else begin
                            n_scan = r_bid - 1'b1;
                            lvl_re = 1'b1;
                            lvl_ra = {lobm_pkg::SIDE_BUY, r_bid - 1'b1};
                        end
                    end else if (r_urec.side == lobm_pkg::SIDE_SELL && r_urec.price == r_ask) begin
                        if (32'(r_ask) == PRICE_LEVELS - 1) begin
                            n_has_ask = 1'b0;
                        end else begin
                            n_scan = r_ask + 1'b1;
                            lvl_re = 1'b1;
                            lvl_ra = {lobm_pkg::SIDE_SELL, r_ask + 1'b1};
                        end
                    end
                end else if (r_lvl_rd.head == r_us) begin
                    lvl_we = 1'b1;
                    lvl_wd = '{valid: 1'b1, head: r_urec.next, tail: r_lvl_rd.tail};
                end else if (r_lvl_rd.tail == r_us) begin
                    lvl_we = 1'b1;
                    lvl_wd = '{valid: 1'b1, head: r_lvl_rd.head, tail: r_urec.prev};
                end else begin
                    slot_we_next = 1'b1;
                    slot_wa      = r_urec.prev;
                    slot_wd.next = r_urec.next;
                end
            end
            lobm_pkg::S_UN_MID: begin
                slot_we_prev = 1'b1;
                slot_wa      = r_urec.next;
                slot_wd.prev = r_urec.prev;
            end
            // One level per cycle until an occupied level or the end of the range.
            lobm_pkg::S_SCAN: begin
                if (r_lvl_rd.valid) begin
                    if (r_urec.side == lobm_pkg::SIDE_BUY) n_bid = r_scan;
                    else                                   n_ask = r_scan;
                end else if (r_urec.side == lobm_pkg::SIDE_BUY) begin
                    if (r_scan == '0) begin
                        n_has_bid = 1'b0;
                    end else begin
                        n_scan = r_scan - 1'b1;
                        lvl_re = 1'b1;
                        lvl_ra = {lobm_pkg::SIDE_BUY, r_scan - 1'b1};
                    end
                end else begin
                    if (32'(r_scan) == PRICE_LEVELS - 1) begin
                        n_has_ask = 1'b0;
                    end else begin
                        n_scan = r_scan + 1'b1;
                        lvl_re = 1'b1;
                        lvl_ra = {lobm_pkg::SIDE_SELL, r_scan + 1'b1};
                    end
                end
            end
            lobm_pkg::S_UN_RET: begin
                if (r_umode == lobm_pkg::U_CANCEL) begin
                    w_emit   = 1'b1;
                    w_emit_d = f_simple(lobm_pkg::EV_CANCELLED, r_id);
                end else if (r_umode == lobm_pkg::U_BUY && r_ad) begin
                    n_us    = r_a;
                    n_umode = lobm_pkg::U_SELL;
                end
            end
            // Send the held item as the final one.
            lobm_pkg::S_FLUSH: begin
                if (w_out_free) begin
                    n_out       = r_pend;
                    n_out.last  = 1'b1;
                    n_out_valid = 1'b1;
                    n_pend_v    = 1'b0;
                end
            end
            default: begin
            end
        endcase

        // A new item pushes the held one out, not marked final.
        if (w_emit) begin
            if (r_pend_v) begin
                n_out       = r_pend;
                n_out.last  = 1'b0;
                n_out_valid = 1'b1;
            end
            n_pend   = w_emit_d;
            n_pend_v = 1'b1;
            n_nres   = r_nres + 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lobm_pkg::S_CLEAR;
            r_clr       <= '0;
            r_free_cnt  <= (SB+1)'(ORDER_SLOTS);
            r_has_bid   <= 1'b0;
            r_has_ask   <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_free_cnt  <= n_free_cnt;
            r_has_bid   <= n_has_bid;
            r_has_ask   <= n_has_ask;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_id    <= n_id;
        r_side  <= n_side;
        r_qty   <= n_qty;
        r_price <= n_price;
        r_bid   <= n_bid;
        r_ask   <= n_ask;
        r_slot  <= n_slot;
        r_link  <= n_link;
        r_t     <= n_t;
        r_b     <= n_b;
        r_a     <= n_a;
        r_brec  <= n_brec;
        r_bq    <= n_bq;
        r_bd    <= n_bd;
        r_ad    <= n_ad;
        r_us    <= n_us;
        r_umode <= n_umode;
        r_urec  <= n_urec;
        r_scan  <= n_scan;
        r_nres  <= n_nres;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

endmodule

@@ test/tb_limit_order_book_matcher.sv @@
module tb_limit_order_book_matcher;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS  = 64;
    localparam int LEVELS = 256;
    localparam int IDS    = 1024;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    lobm_pkg::t_lob_in  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    lobm_pkg::t_lob_out o_out_data;

    limit_order_book_matcher uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the book.
    logic [9:0]  bk_id    [SLOTS];
    logic        bk_side  [SLOTS];
    logic [15:0] bk_qty   [SLOTS];
    logic [7:0]  bk_price [SLOTS];
    logic [5:0]  bk_prev  [SLOTS];
    logic [5:0]  bk_next  [SLOTS];
    logic [5:0]  free_stack [SLOTS];
    int          free_top;
    logic        resting  [IDS];
    logic [5:0]  id_slot  [IDS];
    logic        lvl_used [2][LEVELS];
    logic [5:0]  lvl_head [2][LEVELS];
    logic [5:0]  lvl_tail [2][LEVELS];
    logic        have_bid, have_ask;
    int          bid_px, ask_px;

    lobm_pkg::t_lob_out expected_events[$];
    int errors = 0;
    int results_seen = 0;
    int trades_seen = 0;
    int sent = 0;

    function automatic void book_reset();
        for (int i = 0; i < SLOTS; i++) begin
            free_stack[i] = 6'(SLOTS - 1 - i);
        end
        free_top = SLOTS;
        for (int i = 0; i < IDS; i++) begin
            resting[i] = 1'b0;
        end
        for (int s = 0; s < 2; s++) begin
            for (int p = 0; p < LEVELS; p++) begin
                lvl_used[s][p] = 1'b0;
            end
        end
        have_bid = 1'b0;
        have_ask = 1'b0;
        bid_px = 0;
        ask_px = 0;
    endfunction

    function automatic void find_best_prices();
        have_bid = 1'b0;
        have_ask = 1'b0;
        for (int p = LEVELS - 1; p >= 0 && !have_bid; p--) begin
            if (lvl_used[0][p]) begin
                have_bid = 1'b1;
                bid_px = p;
            end
        end
        for (int p = 0; p < LEVELS && !have_ask; p++) begin
            if (lvl_used[1][p]) begin
                have_ask = 1'b1;
                ask_px = p;
            end
        end
    endfunction

    function automatic void remove_order(int s);
        int sd;
        int p;
        sd = bk_side[s];
        p = bk_price[s];
        if (lvl_head[sd][p] == s && lvl_tail[sd][p] == s) begin
            lvl_used[sd][p] = 1'b0;
        end else if (lvl_head[sd][p] == s) begin
            lvl_head[sd][p] = bk_next[s];
        end else if (lvl_tail[sd][p] == s) begin
            lvl_tail[sd][p] = bk_prev[s];
        end else begin
            bk_next[bk_prev[s]] = bk_next[s];
            bk_prev[bk_next[s]] = bk_prev[s];
        end
        bk_qty[s] = '0;
        resting[bk_id[s]] = 1'b0;
        free_stack[free_top] = 6'(s);
        free_top++;
        if (!lvl_used[sd][p]) begin
            find_best_prices();
        end
    endfunction

    function automatic lobm_pkg::t_lob_out make_event(lobm_pkg::t_event kind, logic [9:0] id);
        lobm_pkg::t_lob_out e;
        e = '0;
        e.event_kind = kind;
        e.subject_id = id;
        return e;
    endfunction

    // Works out every result one request causes and queues them in order.
    function automatic void predict_request(lobm_pkg::t_lob_in r);
        lobm_pkg::t_lob_out ev [lobm_pkg::MAX_RESULTS];
        lobm_pkg::t_lob_out e;
        int n;
        int s, b, a, sd, p;
        logic [15:0] t;
        n = 0;
        if (r.operation == lobm_pkg::OP_CANCEL) begin
            if (!resting[r.req_id]) begin
                ev[n] = make_event(lobm_pkg::EV_NOT_FOUND, r.req_id);
                n++;
            end else begin
                remove_order(id_slot[r.req_id]);
                ev[n] = make_event(lobm_pkg::EV_CANCELLED, r.req_id);
                n++;
            end
        end else if (r.quantity == 0 || r.price_tick == 0) begin
            ev[n] = make_event(lobm_pkg::EV_BAD, r.req_id);
            n++;
        end else if (resting[r.req_id]) begin
            ev[n] = make_event(lobm_pkg::EV_DUP, r.req_id);
            n++;
        end else if (free_top == 0) begin
            ev[n] = make_event(lobm_pkg::EV_FULL, r.req_id);
            n++;
        end else begin
            free_top--;
            s = free_stack[free_top];
            sd = r.side;
            p = r.price_tick;
            bk_id[s] = r.req_id;
            bk_side[s] = r.side;
            bk_qty[s] = r.quantity;
            bk_price[s] = r.price_tick;
            resting[r.req_id] = 1'b1;
            id_slot[r.req_id] = 6'(s);
            if (!lvl_used[sd][p]) begin
                lvl_used[sd][p] = 1'b1;
                lvl_head[sd][p] = 6'(s);
            end else begin
                bk_prev[s] = lvl_tail[sd][p];
                bk_next[lvl_tail[sd][p]] = 6'(s);
            end
            lvl_tail[sd][p] = 6'(s);
            if (sd == lobm_pkg::SIDE_BUY) begin
                if (!have_bid || p > bid_px) begin
                    have_bid = 1'b1;
                    bid_px = p;
                end
            end else if (!have_ask || p < ask_px) begin
                have_ask = 1'b1;
                ask_px = p;
            end
            ev[n] = make_event(lobm_pkg::EV_PLACED, r.req_id);
            n++;
            // Cross the book while the best prices overlap.
            while (n < lobm_pkg::MAX_RESULTS && have_bid && have_ask && ask_px <= bid_px) begin
                b = lvl_head[0][bid_px];
                a = lvl_head[1][ask_px];
                t = (bk_qty[b] < bk_qty[a]) ? bk_qty[b] : bk_qty[a];
                bk_qty[b] -= t;
                bk_qty[a] -= t;
                e = make_event(lobm_pkg::EV_TRADE, r.req_id);
                e.buy_id = bk_id[b];
                e.sell_id = bk_id[a];
                e.trade_qty = t;
                e.buy_level = bk_price[b];
                e.sell_level = bk_price[a];
                e.buy_done = (bk_qty[b] == 0);
                e.sell_done = (bk_qty[a] == 0);
                ev[n] = e;
                n++;
                if (e.buy_done) remove_order(b);
                if (e.sell_done) remove_order(a);
            end
        end
        ev[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++) begin
            expected_events = {expected_events, ev[i]};
        end
    endfunction

    // Sends one item, with a random gap now and then between bursts.
    int burst_left = 0;
    task automatic send_request(logic op, logic [9:0] id, logic sd, logic [15:0] q,
                                logic [7:0] px);
        lobm_pkg::t_lob_in r;
        int gap;
        r = '{operation: op, req_id: id, side: sd, quantity: q, price_tick: px};
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data <= r;
        do @(posedge i_clk); while (!o_in_ready);
        predict_request(r);
        sent++;
    endtask

    // The receiver stalls on its own changing pattern.
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            default: i_out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Compares each result with the oldest expectation.
    always @(posedge i_clk) begin
        lobm_pkg::t_lob_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, o_out_data);
                errors++;
            end else begin
                want = expected_events[0];
                expected_events.delete(0);
                if (o_out_data.event_kind == lobm_pkg::EV_TRADE) trades_seen++;
                if (o_out_data !== want) begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, want, o_out_data);
                    errors++;
                end
            end
        end
    end

    task automatic test_rejects();
        send_request(lobm_pkg::OP_PLACE, 10'd1, lobm_pkg::SIDE_BUY, 16'd0, 8'd10);
        send_request(lobm_pkg::OP_PLACE, 10'd2, lobm_pkg::SIDE_SELL, 16'd5, 8'd0);
        send_request(lobm_pkg::OP_CANCEL, 10'd1023, lobm_pkg::SIDE_SELL, 16'hFFFF, 8'hFF);
        send_request(lobm_pkg::OP_PLACE, 10'd1023, lobm_pkg::SIDE_BUY, 16'hFFFF, 8'hFF);
        send_request(lobm_pkg::OP_PLACE, 10'd1023, lobm_pkg::SIDE_SELL, 16'd3, 8'd1);
        send_request(lobm_pkg::OP_CANCEL, 10'd1023, lobm_pkg::SIDE_SELL, 16'd0, 8'd0);
        send_request(lobm_pkg::OP_CANCEL, 10'd1023, lobm_pkg::SIDE_BUY, 16'd0, 8'd0);
    endtask

    task automatic test_matching();
        // Queue order at one level, then sweep two levels with one sell.
        send_request(lobm_pkg::OP_PLACE, 10'd10, lobm_pkg::SIDE_BUY, 16'd5, 8'd100);
        send_request(lobm_pkg::OP_PLACE, 10'd11, lobm_pkg::SIDE_BUY, 16'd7, 8'd100);
        send_request(lobm_pkg::OP_PLACE, 10'd12, lobm_pkg::SIDE_BUY, 16'd4, 8'd101);
        send_request(lobm_pkg::OP_PLACE, 10'd13, lobm_pkg::SIDE_SELL, 16'd10, 8'd100);
        send_request(lobm_pkg::OP_PLACE, 10'd14, lobm_pkg::SIDE_SELL, 16'hFFFF, 8'd255);
        send_request(lobm_pkg::OP_PLACE, 10'd15, lobm_pkg::SIDE_BUY, 16'hFFFF, 8'd255);
        send_request(lobm_pkg::OP_CANCEL, 10'd11, lobm_pkg::SIDE_SELL, 16'd0, 8'd0);
        send_request(lobm_pkg::OP_CANCEL, 10'd15, lobm_pkg::SIDE_BUY, 16'd0, 8'd0);
        send_request(lobm_pkg::OP_PLACE, 10'd0, lobm_pkg::SIDE_SELL, 16'd1, 8'd1);
        send_request(lobm_pkg::OP_CANCEL, 10'd0, lobm_pkg::SIDE_BUY, 16'd0, 8'd0);
    endtask

    task automatic test_store_full();
        for (int i = 0; i < SLOTS + 1; i++) begin
            send_request(lobm_pkg::OP_PLACE, 10'(200 + i), lobm_pkg::SIDE_BUY, 16'd1, 8'd5);
        end
        send_request(lobm_pkg::OP_PLACE, 10'd500, lobm_pkg::SIDE_SELL, 16'd100, 8'd1);
    endtask

    // Mostly well-formed orders around a narrow price band so books cross often.
    task automatic test_random_traffic(int count);
        int kind;
        logic [7:0] px;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 99);
            px = 8'($urandom_range(118, 138));
            if (kind < 60) begin
                send_request(lobm_pkg::OP_PLACE, 10'($urandom_range(0, 127)), 1'($urandom),
                             16'($urandom_range(1, 40)), px);
            end else if (kind < 80) begin
                send_request(lobm_pkg::OP_CANCEL, 10'($urandom_range(0, 127)), 1'($urandom),
                             16'($urandom), 8'($urandom));
            end else begin
                send_request(1'($urandom), 10'($urandom), 1'($urandom),
                             ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom),
                             ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom));
            end
        end
    endtask

    initial begin
        book_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_rejects();
        test_matching();
        test_store_full();
        test_random_traffic(170);
        i_in_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        $display("Sent %0d requests and checked %0d results, %0d of them trades.",
                 sent, results_seen, trades_seen);
        if (errors == 0 && expected_events.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
